@@ src/ezr_pkg.sv @@
// Shared constants, types and the CORDIC arctangent table of the Euler ZYX point rotator.
// No dependencies; every other file of the block uses this package by scoped name.
package ezr_pkg;

  localparam int POS_WIDTH_DEF      = 24;
  localparam int ANGLE_WIDTH_DEF    = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  localparam int NUM_AXES     = 3;
  localparam int AXIS_AZ      = 0;
  localparam int AXIS_EL      = 1;
  localparam int AXIS_RL      = 2;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_WIDTH = 32;
  localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

  // One sine/cosine rotation in flight: x, y in Q2.30, z in 2^-32 turn units.
  typedef struct packed {
    logic signed [CORDIC_WIDTH-1:0] x;
    logic signed [CORDIC_WIDTH-1:0] y;
    logic signed [CORDIC_WIDTH-1:0] z;
  } cordic_lane_t;

  // atan(2^-step) in 2^-32 turn units
  function automatic logic [CORDIC_WIDTH-1:0] atan_turn(input int step);
    logic [CORDIC_WIDTH-1:0] val;
    case (step)
      0:       val = 32'h20000000;
      1:       val = 32'h12E4051D;
      2:       val = 32'h09FB385B;
      3:       val = 32'h051111D4;
      4:       val = 32'h028B0D43;
      5:       val = 32'h0145D7E1;
      6:       val = 32'h00A2F61E;
      7:       val = 32'h00517C55;
      8:       val = 32'h0028BE53;
      9:       val = 32'h00145F2F;
      10:      val = 32'h000A2F98;
      11:      val = 32'h000517CC;
      12:      val = 32'h00028BE6;
      13:      val = 32'h000145F3;
      14:      val = 32'h0000A2FA;
      15:      val = 32'h0000517D;
      16:      val = 32'h000028BE;
      17:      val = 32'h0000145F;
      18:      val = 32'h00000A30;
      19:      val = 32'h00000518;
      20:      val = 32'h0000028C;
      21:      val = 32'h00000146;
      22:      val = 32'h000000A3;
      23:      val = 32'h00000051;
      24:      val = 32'h00000029;
      25:      val = 32'h00000014;
      26:      val = 32'h0000000A;
      27:      val = 32'h00000005;
      28:      val = 32'h00000003;
      29:      val = 32'h00000001;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ src/euler_zyx_point_rotator.sv @@
// Euler ZYX point rotator top level: CORDIC cell chain, trig rounding, three
// plane rotations and output saturation. Depends on ezr_pkg, ezr_cordic_cell, ezr_rotate.
//
// Usage:
//   Drive pos_x_i/pos_y_i/pos_z_i and azimuth_i/elevation_i/roll_i and pulse
//   start; a transaction is taken at every edge with start high and busy low.
//   busy stays low: the pipeline takes one transaction every clock cycle.
//   Each transaction gives one result on rot_x_o/rot_y_o/rot_z_o/saturated_o,
//   shown for exactly one cycle with done_o high. Results leave in the order
//   the transactions came in.
//   The pipeline holds the 30 CORDIC cells (one micro-rotation each), one trig
//   rounding stage, three plane rotations of two stages each (multiply, then
//   round) and one saturation stage.
//   The receiver cannot stall the block; a result not taken in its cycle is gone.
//   Reset clears all valid flags, so no result appears until new transactions
//   are started; data in flight at reset is dropped.
module euler_zyx_point_rotator #(
  parameter int POS_WIDTH      = ezr_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH    = ezr_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = ezr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [POS_WIDTH-1:0]   pos_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] azimuth_i,
  input  logic signed [ANGLE_WIDTH-1:0] elevation_i,
  input  logic signed [ANGLE_WIDTH-1:0] roll_i,
  output logic                          done_o,
  output logic signed [POS_WIDTH-1:0]   rot_x_o,
  output logic signed [POS_WIDTH-1:0]   rot_y_o,
  output logic signed [POS_WIDTH-1:0]   rot_z_o,
  output logic                          saturated_o
);

  localparam int NA    = ezr_pkg::NUM_AXES;
  localparam int STEPS = ezr_pkg::CORDIC_STEPS;
  localparam int CW    = ezr_pkg::CORDIC_WIDTH;
  localparam int PW    = POS_WIDTH;
  localparam int IW    = POS_WIDTH + 2;
  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int SH    = ezr_pkg::CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam logic signed [CW:0] TRND = (CW + 1)'(1) << (SH - 1);

  // ---------------------------------------------------------------- CORDIC chain
  logic                                   vld_c  [0:STEPS];
  ezr_pkg::cordic_lane_t [NA-1:0]         lane_c [0:STEPS];
  logic [NA-1:0]                          neg_c  [0:STEPS];
  logic [NA*PW-1:0]                       pos_c  [0:STEPS];
  logic [ANGLE_WIDTH-1:0]                 ang    [NA];

  assign busy = 1'b0;
  assign vld_c[0] = start & ~busy;
  assign pos_c[0] = {pos_z_i, pos_y_i, pos_x_i};
  assign ang[ezr_pkg::AXIS_AZ] = azimuth_i;
  assign ang[ezr_pkg::AXIS_EL] = elevation_i;
  assign ang[ezr_pkg::AXIS_RL] = roll_i;

  // Fold the turn into [-90, 90) degrees; flag the lanes whose trig gets negated.
  always_comb begin
    logic [CW-1:0] turn;
    logic          neg;
    for (int k = 0; k < NA; k++) begin
      turn = {ang[k], {(CW - ANGLE_WIDTH){1'b0}}};
      neg  = turn[CW-1] ^ turn[CW-2];
      neg_c[0][k]    = neg;
      lane_c[0][k].x = ezr_pkg::CORDIC_GAIN;
      lane_c[0][k].y = '0;
      lane_c[0][k].z = {turn[CW-1] ^ neg, turn[CW-2:0]};
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    ezr_cordic_cell #(
      .STEP (g),
      .PW   (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[g]),
      .lane_i  (lane_c[g]),
      .neg_i   (neg_c[g]),
      .pos_i   (pos_c[g]),
      .valid_o (vld_c[g+1]),
      .lane_o  (lane_c[g+1]),
      .neg_o   (neg_c[g+1]),
      .pos_o   (pos_c[g+1])
    );
  end

  // ---------------------------------------------------------------- trig rounding
  logic                 vld_t_q;
  logic [NA*PW-1:0]     pos_t_q;
  logic signed [TW-1:0] cos_d [NA];
  logic signed [TW-1:0] sin_d [NA];
  logic signed [TW-1:0] cos_q [NA];
  logic signed [TW-1:0] sin_q [NA];

  always_comb begin
    logic signed [CW:0] xr;
    logic signed [CW:0] yr;
    logic signed [TW-1:0] cv;
    logic signed [TW-1:0] sv;
    for (int k = 0; k < NA; k++) begin
      xr = ({lane_c[STEPS][k].x[CW-1], lane_c[STEPS][k].x} + TRND) >>> SH;
      yr = ({lane_c[STEPS][k].y[CW-1], lane_c[STEPS][k].y} + TRND) >>> SH;
      cv = xr[TW-1:0];
      sv = yr[TW-1:0];
      cos_d[k] = neg_c[STEPS][k] ? -cv : cv;
      sin_d[k] = neg_c[STEPS][k] ? -sv : sv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t_q <= 1'b0;
    end else begin
      vld_t_q <= vld_c[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    pos_t_q <= pos_c[STEPS];
    for (int k = 0; k < NA; k++) begin
      cos_q[k] <= cos_d[k];
      sin_q[k] <= sin_d[k];
    end
  end

  // ---------------------------------------------------------------- rotations
  logic signed [PW-1:0] px, py, pz;
  logic signed [IW-1:0] x_ext, y_ext, z_ext;

  assign px    = pos_t_q[PW-1:0];
  assign py    = pos_t_q[2*PW-1:PW];
  assign pz    = pos_t_q[3*PW-1:2*PW];
  assign x_ext = {{2{px[PW-1]}}, px};
  assign y_ext = {{2{py[PW-1]}}, py};
  assign z_ext = {{2{pz[PW-1]}}, pz};

  // Side data waits beside the rotations that come first.
  logic signed [IW-1:0]   z_dly_q  [0:1];
  logic [2*TW-1:0]        el_dly_q [0:1];
  logic [2*TW-1:0]        rl_dly_q [0:3];
  logic signed [IW-1:0]   y1_dly_q [0:1];
  logic signed [IW-1:0]   rx_dly_q [0:1];

  logic                 vld_a, vld_e, vld_r;
  logic signed [IW-1:0] x1, y1, z1, rx, ry, rz;
  logic signed [TW-1:0] ce, se, cr, sr;

  assign ce = el_dly_q[1][2*TW-1:TW];
  assign se = el_dly_q[1][TW-1:0];
  assign cr = rl_dly_q[3][2*TW-1:TW];
  assign sr = rl_dly_q[3][TW-1:0];

  always_ff @(posedge clk_i) begin
    z_dly_q[0]  <= z_ext;
    z_dly_q[1]  <= z_dly_q[0];
    el_dly_q[0] <= {cos_q[ezr_pkg::AXIS_EL], sin_q[ezr_pkg::AXIS_EL]};
    el_dly_q[1] <= el_dly_q[0];
    rl_dly_q[0] <= {cos_q[ezr_pkg::AXIS_RL], sin_q[ezr_pkg::AXIS_RL]};
    for (int k = 1; k < 4; k++) begin
      rl_dly_q[k] <= rl_dly_q[k-1];
    end
    y1_dly_q[0] <= y1;
    y1_dly_q[1] <= y1_dly_q[0];
    rx_dly_q[0] <= rx;
    rx_dly_q[1] <= rx_dly_q[0];
  end

  // about z: x1 = x*cA + y*sA, y1 = y*cA - x*sA
  ezr_rotate #(.IW(IW), .TW(TW), .FB(TRIG_FRAC_BITS)) u_rot_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_t_q),
    .a_i     (x_ext),
    .b_i     (y_ext),
    .c_i     (cos_q[ezr_pkg::AXIS_AZ]),
    .s_i     (sin_q[ezr_pkg::AXIS_AZ]),
    .valid_o (vld_a),
    .o1_o    (x1),
    .o2_o    (y1)
  );

  // about y: z1 = z*cE + x1*sE, rot_x = x1*cE - z*sE
  ezr_rotate #(.IW(IW), .TW(TW), .FB(TRIG_FRAC_BITS)) u_rot_el (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_a),
    .a_i     (z_dly_q[1]),
    .b_i     (x1),
    .c_i     (ce),
    .s_i     (se),
    .valid_o (vld_e),
    .o1_o    (z1),
    .o2_o    (rx)
  );

  // about x: rot_y = y1*cR + z1*sR, rot_z = z1*cR - y1*sR
  ezr_rotate #(.IW(IW), .TW(TW), .FB(TRIG_FRAC_BITS)) u_rot_rl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_e),
    .a_i     (y1_dly_q[1]),
    .b_i     (z1),
    .c_i     (cr),
    .s_i     (sr),
    .valid_o (vld_r),
    .o1_o    (ry),
    .o2_o    (rz)
  );

  // ---------------------------------------------------------------- saturation
  logic signed [IW-1:0] fin   [NA];
  logic signed [PW-1:0] clp_d [NA];
  logic                 sat_d;
  logic                 done_q;
  logic signed [PW-1:0] rot_x_q, rot_y_q, rot_z_q;
  logic                 sat_q;

  assign fin[0] = rx_dly_q[1];
  assign fin[1] = ry;
  assign fin[2] = rz;

  always_comb begin
    logic [IW-PW:0] top;
    sat_d = 1'b0;
    for (int k = 0; k < NA; k++) begin
      top = fin[k][IW-1:PW-1];
      if ((&top) || !(|top)) begin
        clp_d[k] = fin[k][PW-1:0];
      end else begin
        // clip to the nearest bound
        clp_d[k] = fin[k][IW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        sat_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_r;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_x_q <= clp_d[0];
    rot_y_q <= clp_d[1];
    rot_z_q <= clp_d[2];
    sat_q   <= sat_d;
  end

  assign done_o      = done_q;
  assign rot_x_o     = rot_x_q;
  assign rot_y_o     = rot_y_q;
  assign rot_z_o     = rot_z_q;
  assign saturated_o = sat_q;

endmodule

@@ src/ezr_cordic_cell.sv @@
// One CORDIC rotation-mode micro-rotation for the three angle lanes of a transaction.
// Carries the position and the quadrant flags along. Depends on ezr_pkg.
module ezr_cordic_cell #(
  parameter int STEP = 0,
  parameter int PW   = ezr_pkg::POS_WIDTH_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  ezr_pkg::cordic_lane_t [ezr_pkg::NUM_AXES-1:0] lane_i,
  input  logic [ezr_pkg::NUM_AXES-1:0]                  neg_i,
  input  logic [ezr_pkg::NUM_AXES*PW-1:0]               pos_i,
  output logic                                          valid_o,
  output ezr_pkg::cordic_lane_t [ezr_pkg::NUM_AXES-1:0] lane_o,
  output logic [ezr_pkg::NUM_AXES-1:0]                  neg_o,
  output logic [ezr_pkg::NUM_AXES*PW-1:0]               pos_o
);

  localparam logic signed [ezr_pkg::CORDIC_WIDTH-1:0] ATAN = ezr_pkg::atan_turn(STEP);

  logic                                          valid_q;
  ezr_pkg::cordic_lane_t [ezr_pkg::NUM_AXES-1:0] lane_d, lane_q;
  logic [ezr_pkg::NUM_AXES-1:0]                  neg_q;
  logic [ezr_pkg::NUM_AXES*PW-1:0]               pos_q;

  always_comb begin
    logic signed [ezr_pkg::CORDIC_WIDTH-1:0] dx;
    logic signed [ezr_pkg::CORDIC_WIDTH-1:0] dy;
    for (int k = 0; k < ezr_pkg::NUM_AXES; k++) begin
      dx = lane_i[k].y >>> STEP;
      dy = lane_i[k].x >>> STEP;
      // rotate toward zero residual angle
      if (!lane_i[k].z[ezr_pkg::CORDIC_WIDTH-1]) begin
        lane_d[k].x = lane_i[k].x - dx;
        lane_d[k].y = lane_i[k].y + dy;
        lane_d[k].z = lane_i[k].z - ATAN;
      end else begin
        lane_d[k].x = lane_i[k].x + dx;
        lane_d[k].y = lane_i[k].y - dy;
        lane_d[k].z = lane_i[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    neg_q  <= neg_i;
    pos_q  <= pos_i;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign neg_o   = neg_q;
  assign pos_o   = pos_q;

endmodule

@@ src/ezr_rotate.sv @@
// Plane rotation of one coordinate pair: o1 = a*c + b*s, o2 = b*c - a*s, rounded.
// Two register stages: products, then rounded sums. Depends on ezr_pkg for defaults.
module ezr_rotate #(
  parameter int IW = ezr_pkg::POS_WIDTH_DEF + 2,
  parameter int TW = ezr_pkg::TRIG_FRAC_BITS_DEF + 2,
  parameter int FB = ezr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [IW-1:0] a_i,
  input  logic signed [IW-1:0] b_i,
  input  logic signed [TW-1:0] c_i,
  input  logic signed [TW-1:0] s_i,
  output logic                 valid_o,
  output logic signed [IW-1:0] o1_o,
  output logic signed [IW-1:0] o2_o
);

  localparam int PW_ = IW + TW;
  localparam int SW  = PW_ + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) << (FB - 1);

  logic                  valid_p_q, valid_s_q;
  logic signed [PW_-1:0] ac_d, bs_d, bc_d, as_d;
  logic signed [PW_-1:0] ac_q, bs_q, bc_q, as_q;
  logic signed [SW-1:0]  sum1, sum2, sh1, sh2;
  logic signed [IW-1:0]  o1_q, o2_q;

  assign ac_d = a_i * c_i;
  assign bs_d = b_i * s_i;
  assign bc_d = b_i * c_i;
  assign as_d = a_i * s_i;

  assign sum1 = {ac_q[PW_-1], ac_q} + {bs_q[PW_-1], bs_q} + RND;
  assign sum2 = {bc_q[PW_-1], bc_q} - {as_q[PW_-1], as_q} + RND;
  assign sh1  = sum1 >>> FB;
  assign sh2  = sum2 >>> FB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
      valid_s_q <= 1'b0;
    end else begin
      valid_p_q <= valid_i;
      valid_s_q <= valid_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ac_q <= ac_d;
    bs_q <= bs_d;
    bc_q <= bc_d;
    as_q <= as_d;
    o1_q <= sh1[IW-1:0];
    o2_q <= sh2[IW-1:0];
  end

  assign valid_o = valid_s_q;
  assign o1_o    = o1_q;
  assign o2_o    = o2_q;

endmodule
